@@ hw/rtl/eft_pkg.sv @@
// ----------------------------------------------------------------------------
// eft_pkg: shared types and helpers for the Euler frame transform.
// Holds the sine table generator, the register indexes and the channel items.
// ----------------------------------------------------------------------------
package eft_pkg;

  localparam int SINE_TABLE_BITS_DEFAULT = 10;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_PITCH = 3'd0;
  localparam logic [2:0] REG_ROLL  = 3'd1;
  localparam logic [2:0] REG_YAW   = 3'd2;
  localparam logic [2:0] REG_OFS_X = 3'd3;
  localparam logic [2:0] REG_OFS_Y = 3'd4;
  localparam logic [2:0] REG_OFS_Z = 3'd5;

  localparam logic CMD_L2G = 1'b0;
  localparam logic CMD_G2L = 1'b1;

  localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
  localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

  typedef struct packed {
    logic               command;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;
  } out_item_t;

  // Sine and cosine of one angle, Q2.15.
  typedef struct packed {
    logic signed [16:0] s;
    logic signed [16:0] c;
  } trig_t;

  // Quarter-wave entry k, evaluated at elaboration only.
  function automatic logic [15:0] table_entry(input int unsigned k, input int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    int unsigned divs [6];
    divs = '{156, 110, 72, 42, 20, 6};
    x = (64'(k) * 64'd1686629713) >> bits;
    x2 = (x * x) >> 30;
    t = 64'd1 << 30;
    for (int d = 0; d < 6; d++) begin
      t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'(divs[d]));
    end
    s = (x * t) >> 30;
    r = (s + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[15:0];
  endfunction

  // Clamp a 34-bit value to 32 bits; flag reports a clamp.
  function automatic logic [32:0] clamp32(input logic signed [33:0] v);
    if (v > SAT_MAX) begin
      return {1'b1, 32'h7FFF_FFFF};
    end else if (v < SAT_MIN) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[31:0]};
  endfunction

endpackage

@@ hw/rtl/eft_stream_if.sv @@
// ----------------------------------------------------------------------------
// eft_stream_if: valid/ready channel carrying one item of type item_t.
// ----------------------------------------------------------------------------
interface eft_stream_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/euler_frame_transform.sv @@
// ----------------------------------------------------------------------------
// euler_frame_transform: moves a 3D point between local and global frames.
// Throughput is one item per cycle, set by a fully pipelined datapath of
// three rotation units (two stages each) and two offset stages, stalled as
// a whole.
// Reset (synchronous) clears the valid bits and the configuration registers;
// datapath registers are not reset.
// ----------------------------------------------------------------------------
module euler_frame_transform import eft_pkg::*; #(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  eft_stream_if.sink   in_ch,
  eft_stream_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = 8;

  logic [15:0]        pitch_turns;
  logic [15:0]        roll_turns;
  logic [15:0]        yaw_turns;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  logic signed [31:0] offset_z;
  logic [2:0]         reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel & penable & pwrite;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_turns <= '0;
      roll_turns  <= '0;
      yaw_turns   <= '0;
      offset_x    <= '0;
      offset_y    <= '0;
      offset_z    <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PITCH: pitch_turns <= pwdata[15:0];
        REG_ROLL:  roll_turns  <= pwdata[15:0];
        REG_YAW:   yaw_turns   <= pwdata[15:0];
        REG_OFS_X: offset_x    <= pwdata;
        REG_OFS_Y: offset_y    <= pwdata;
        REG_OFS_Z: offset_z    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PITCH: prdata = {16'd0, pitch_turns};
      REG_ROLL:  prdata = {16'd0, roll_turns};
      REG_YAW:   prdata = {16'd0, yaw_turns};
      REG_OFS_X: prdata = offset_x;
      REG_OFS_Y: prdata = offset_y;
      REG_OFS_Z: prdata = offset_z;
      default:   prdata = '0;
    endcase
  end

  // Trig values, registered every clock from the angle registers; stable while the angles are not written.
  trig_t tp;
  trig_t tr;
  trig_t ty;
  eft_trig #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_trig_p (.clk, .angle(pitch_turns), .trig(tp));
  eft_trig #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_trig_r (.clk, .angle(roll_turns), .trig(tr));
  eft_trig #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_trig_y (.clk, .angle(yaw_turns), .trig(ty));

  // Pipeline control: whole pipe advances when the output slot frees.
  logic [DEPTH-1:0] vld;
  logic             adv;
  assign adv         = !vld[DEPTH-1] || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_ch.valid};
    end
  end

  // Command travels alongside the data.
  logic [DEPTH-1:0] cmd;
  logic [DEPTH-1:0] sat;
  always_ff @(posedge clk) begin
    if (adv) begin
      cmd <= {cmd[DEPTH-2:0], in_ch.data.command};
    end
  end

  // Stage 0: entry register, with the offset subtract for global to local.
  logic signed [31:0] s0x, s0y, s0z;
  logic [32:0] cx0, cy0, cz0;
  always_comb begin
    cx0 = clamp32(34'(in_ch.data.in_x) - 34'(offset_x));
    cy0 = clamp32(34'(in_ch.data.in_y) - 34'(offset_y));
    cz0 = clamp32(34'(in_ch.data.in_z) - 34'(offset_z));
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      if (in_ch.data.command == CMD_G2L) begin
        s0x <= cx0[31:0];
        s0y <= cy0[31:0];
        s0z <= cz0[31:0];
      end else begin
        s0x <= in_ch.data.in_x;
        s0y <= in_ch.data.in_y;
        s0z <= in_ch.data.in_z;
      end
    end
  end

  // First rotation: pitch (local to global) or yaw (global to local).
  logic g1;
  assign g1 = (cmd[0] == CMD_G2L);
  logic signed [31:0] r1a, r1b;
  logic               r1s;
  eft_rotate u_rot1 (
    .clk, .en(adv),
    .u(s0x), .v(g1 ? s0z : s0y),
    .a0(g1 ? -ty.s : tp.c), .b0(g1 ? ty.c : -tp.s),
    .a1(g1 ? ty.c : tp.s), .b1(g1 ? ty.s : tp.c),
    .r0(r1a), .r1(r1b), .sat(r1s)
  );
  logic signed [31:0] p1x, p1y, p1z, p2x, p2y, p2z;
  always_ff @(posedge clk) begin
    if (adv) begin
      p1x <= s0x; p1y <= s0y; p1z <= s0z;
      p2x <= p1x; p2y <= p1y; p2z <= p1z;
    end
  end
  // After stage 2: l2g gives x=r1a,y=r1b; g2l gives x=r1a,z=r1b.
  logic signed [31:0] q2x, q2y, q2z;
  always_comb begin
    q2x = r1a;
    q2y = (cmd[2] == CMD_G2L) ? p2y : r1b;
    q2z = (cmd[2] == CMD_G2L) ? r1b : p2z;
  end

  // Second rotation: roll in both directions.
  logic g2;
  assign g2 = (cmd[2] == CMD_G2L);
  logic signed [31:0] r2a, r2b;
  logic               r2s;
  eft_rotate u_rot2 (
    .clk, .en(adv),
    .u(q2y), .v(q2z),
    .a0(tr.c), .b0(g2 ? -tr.s : tr.s),
    .a1(g2 ? tr.s : -tr.s), .b1(tr.c),
    .r0(r2a), .r1(r2b), .sat(r2s)
  );
  logic signed [31:0] p3x, p4x;
  always_ff @(posedge clk) begin
    if (adv) begin
      p3x <= q2x; p4x <= p3x;
    end
  end

  // Third rotation: yaw (local to global) or pitch (global to local).
  logic g3;
  assign g3 = (cmd[4] == CMD_G2L);
  logic signed [31:0] r3a, r3b;
  logic               r3s;
  eft_rotate u_rot3 (
    .clk, .en(adv),
    .u(p4x), .v(g3 ? r2a : r2b),
    .a0(g3 ? tp.c : -ty.s), .b0(g3 ? tp.s : ty.c),
    .a1(g3 ? -tp.s : ty.c), .b1(g3 ? tp.c : ty.s),
    .r0(r3a), .r1(r3b), .sat(r3s)
  );
  logic signed [31:0] p5y, p5z, p6y, p6z;
  always_ff @(posedge clk) begin
    if (adv) begin
      p5y <= r2a; p5z <= r2b;
      p6y <= p5y; p6z <= p5z;
    end
  end

  // Final stage: offset add for local to global, output register.
  logic signed [31:0] fx, fy, fz;
  logic [32:0] ax, ay, az;
  logic signed [31:0] out_x, out_y, out_z;
  always_comb begin
    if (cmd[6] == CMD_G2L) begin
      fx = r3a; fy = r3b; fz = p6z;
    end else begin
      fx = r3a; fy = p6y; fz = r3b;
    end
    ax = clamp32(34'(fx) + 34'(offset_x));
    ay = clamp32(34'(fy) + 34'(offset_y));
    az = clamp32(34'(fz) + 34'(offset_z));
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      if (cmd[6] == CMD_G2L) begin
        out_x <= fx;
        out_y <= fy;
        out_z <= fz;
      end else begin
        out_x <= ax[31:0];
        out_y <= ay[31:0];
        out_z <= az[31:0];
      end
    end
  end

  // Saturation flags travel with the data and collect every clamp.
  always_ff @(posedge clk) begin
    if (adv) begin
      sat[0] <= (in_ch.data.command == CMD_G2L) ? (cx0[32] | cy0[32] | cz0[32]) : 1'b0;
      sat[1] <= sat[0];
      sat[2] <= sat[1];
      sat[3] <= sat[2] | r1s;
      sat[4] <= sat[3];
      sat[5] <= sat[4] | r2s;
      sat[6] <= sat[5];
      sat[7] <= (cmd[6] == CMD_G2L) ? (sat[6] | r3s)
                                    : (sat[6] | r3s | ax[32] | ay[32] | az[32]);
    end
  end

  assign out_ch.data.out_x     = out_x;
  assign out_ch.data.out_y     = out_y;
  assign out_ch.data.out_z     = out_z;
  assign out_ch.data.saturated = sat[DEPTH-1];

  // A stalled output item holds its valid bit.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("output item dropped under stall");
  // Input is taken exactly when the pipe advances.
  a_adv: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> vld[0])
    else $error("accepted item lost at entry");
  // The pipe never shifts while the full output is stalled.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> $stable(vld))
    else $error("pipeline moved during stall");

endmodule

@@ hw/rtl/eft_trig.sv @@
// ----------------------------------------------------------------------------
// eft_trig: registered sine and cosine lookup for one angle.
// Uses a constant quarter-wave table; the result is valid in the following cycle.
// ----------------------------------------------------------------------------
module eft_trig import eft_pkg::*; #(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic [15:0] angle,
  output trig_t       trig
);

  localparam int N = 1 << SINE_TABLE_BITS;

  logic [15:0] sine_rom [N+1];
  for (genvar k = 0; k <= N; k++) begin : g_rom
    assign sine_rom[k] = table_entry(k, SINE_TABLE_BITS);
  end

  // Quadrant folding for one angle.
  function automatic logic signed [16:0] lookup(input logic [15:0] a);
    logic [SINE_TABLE_BITS-1:0] i;
    logic [SINE_TABLE_BITS:0]   idx;
    logic signed [16:0]         v;
    i = a[13 -: SINE_TABLE_BITS];
    idx = a[14] ? ((SINE_TABLE_BITS+1)'(N) - {1'b0, i}) : {1'b0, i};
    v = signed'({1'b0, sine_rom[idx]});
    return a[15] ? -v : v;
  endfunction

  logic [15:0] angle_c;
  assign angle_c = angle + 16'd16384;

  always_ff @(posedge clk) begin
    trig.s <= lookup(angle);
    trig.c <= lookup(angle_c);
  end

endmodule

@@ hw/rtl/eft_rotate.sv @@
// ----------------------------------------------------------------------------
// eft_rotate: one pipelined plane rotation stage, built from a product register
// that forms four products and an output register that sums, shifts and clamps.
// ----------------------------------------------------------------------------
module eft_rotate import eft_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] u,
  input  logic signed [31:0] v,
  input  logic signed [16:0] a0,
  input  logic signed [16:0] b0,
  input  logic signed [16:0] a1,
  input  logic signed [16:0] b1,
  output logic signed [31:0] r0,
  output logic signed [31:0] r1,
  output logic               sat
);

  logic signed [48:0] p0a;
  logic signed [48:0] p0b;
  logic signed [48:0] p1a;
  logic signed [48:0] p1b;
  logic signed [49:0] sum0;
  logic signed [49:0] sum1;
  logic [32:0]        c0;
  logic [32:0]        c1;

  // Product registers.
  always_ff @(posedge clk) begin
    if (en) begin
      p0a <= u * a0;
      p0b <= v * b0;
      p1a <= u * a1;
      p1b <= v * b1;
    end
  end

  // Sum, floor shift and clamp.
  always_comb begin
    sum0 = 50'(p0a) + 50'(p0b);
    sum1 = 50'(p1a) + 50'(p1b);
    c0 = clamp32(34'(sum0 >>> 15));
    c1 = clamp32(34'(sum1 >>> 15));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0  <= c0[31:0];
      r1  <= c1[31:0];
      sat <= c0[32] | c1[32];
    end
  end

endmodule
